### design/cff_pkg.sv
package cff_pkg;

   localparam int MAX_LINE_LENGTH = 4096;
   localparam int ADDR_W = $clog2(MAX_LINE_LENGTH);
   localparam int LEN_W = $clog2(MAX_LINE_LENGTH + 1);
   localparam int SUM_W = ADDR_W + 1;

   localparam int SAMPLE_W = 16;
   localparam int GAIN_W = 16;
   localparam int DELAY_W = 13;
   localparam int LINE_LEN_W = 13;
   localparam int DIFF_W = ((LEN_W > DELAY_W) ? LEN_W : DELAY_W) + 1;

   localparam int PROD_W = SAMPLE_W + GAIN_W;
   localparam int FRAC_SHIFT = 14;
   localparam int ROUND_HALF = 1 << (FRAC_SHIFT - 1);
   localparam int RND_W = PROD_W - FRAC_SHIFT + 1;
   localparam int ACC_W = RND_W + 1;
   localparam int SAT_MAX = 2 ** (SAMPLE_W - 1) - 1;
   localparam int SAT_MIN = -(2 ** (SAMPLE_W - 1));

   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;
   localparam int CSR_IDX_BIT = 2;
   localparam logic REG_LINE_LENGTH = 1'b0;
   localparam logic REG_PASSTHROUGH = 1'b1;

   localparam int Q_DEPTH = 4;
   localparam int Q_PTR_W = $clog2(Q_DEPTH);
   localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

   typedef logic signed [SAMPLE_W-1:0] sample_type;
   typedef logic signed [GAIN_W-1:0] gain_type;
   typedef logic signed [PROD_W-1:0] prod_type;
   typedef logic [ADDR_W-1:0] addr_type;
   typedef logic [LEN_W-1:0] len_type;

   typedef struct packed {
      logic push;
      logic pop;
   } q_ctl_type;

   // q1.15 plus rounded q3.29 product, saturated to q1.15
   function automatic sample_type round_sat(sample_type a, prod_type p);
      logic signed [PROD_W:0] pr;
      logic signed [RND_W-1:0] t;
      logic signed [ACC_W-1:0] s;
      pr = (PROD_W + 1)'(p) + (PROD_W + 1)'(ROUND_HALF);
      t = pr[PROD_W:FRAC_SHIFT];
      s = ACC_W'(a) + ACC_W'(t);
      if (s > ACC_W'(SAT_MAX)) begin
         return sample_type'(SAT_MAX);
      end else if (s < ACC_W'(SAT_MIN)) begin
         return sample_type'(SAT_MIN);
      end else begin
         return sample_type'(s[SAMPLE_W-1:0]);
      end
   endfunction

endpackage

### design/cff_ram.sv
module cff_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 4096
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

### design/cff_out_q.sv
module cff_out_q (
   input  logic                 clock,
   input  logic                 reset,
   input  cff_pkg::q_ctl_type   ctl,
   input  cff_pkg::sample_type  push_data,
   output logic                 q_valid,
   output cff_pkg::sample_type  q_data
);

   import cff_pkg::*;

   sample_type         mem_ff [Q_DEPTH];
   logic [Q_PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [Q_PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [Q_CNT_W-1:0] cnt_ff, cnt_in;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      if (ctl.push) begin
         wr_ptr_in = (wr_ptr_ff == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : wr_ptr_ff + Q_PTR_W'(1);
      end
      if (ctl.pop) begin
         rd_ptr_in = (rd_ptr_ff == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : rd_ptr_ff + Q_PTR_W'(1);
      end
      cnt_in = cnt_ff + Q_CNT_W'(ctl.push) - Q_CNT_W'(ctl.pop);
   end

   always_ff @(posedge clock) begin
      if (ctl.push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff <= cnt_in;
      end
   end

   assign q_valid = (cnt_ff != '0);
   assign q_data = mem_ff[rd_ptr_ff];

endmodule

### design/comb_filter_ff_fb.sv
// path: an accepted item passes stage registers s1 to s5, then enters the output queue
// issue: no new item is taken while one is in stage 1, as the single read port of the
//   delay store serves its feedback read and then its feedforward read
// reset: synchronous, clears control state, valid flags, write position and fill count;
//   store entries not written since reset or a length change read as zero
module comb_filter_ff_fb (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_stall,
   input  cff_pkg::sample_type              req_sample_in,
   input  logic [cff_pkg::DELAY_W-1:0]      req_delay_samples,
   input  cff_pkg::gain_type                req_feedforward_gain,
   input  cff_pkg::gain_type                req_feedback_gain,
   output logic                             rsp_valid,
   input  logic                             rsp_stall,
   output cff_pkg::sample_type              rsp_sample_out,
   input  logic                             csr_psel,
   input  logic                             csr_penable,
   input  logic                             csr_pwrite,
   input  logic [cff_pkg::CSR_ADDR_W-1:0]   csr_paddr,
   input  logic [cff_pkg::CSR_DATA_W-1:0]   csr_pwdata,
   output logic [cff_pkg::CSR_DATA_W-1:0]   csr_prdata,
   output logic                             csr_pready
);

   import cff_pkg::*;

   typedef struct packed {
      logic       byp;
      sample_type byp_val;
      sample_type x;
      gain_type   ffg;
      gain_type   fbg;
      addr_type   off;
   } s1_type;

   typedef struct packed {
      logic       byp;
      sample_type byp_val;
      sample_type x;
      gain_type   ffg;
      gain_type   fbg;
      addr_type   wp;
      addr_type   idx1;
      logic       v1;
   } s2_type;

   typedef struct packed {
      logic       byp;
      sample_type byp_val;
      sample_type x;
      gain_type   ffg;
      addr_type   wp;
      prod_type   prod1;
      logic       v2;
      logic       fwd2;
   } s3_type;

   typedef struct packed {
      logic       byp;
      sample_type byp_val;
      addr_type   wp;
      sample_type sum;
      sample_type d2;
      gain_type   ffg;
   } s4_type;

   typedef struct packed {
      logic       byp;
      sample_type byp_val;
      sample_type sum;
      prod_type   prod2;
   } s5_type;

   // configuration
   logic [LINE_LEN_W-1:0] line_len_ff, line_len_in;
   len_type               eff_len_ff, eff_len_in;
   logic                  pass_ff, pass_in;
   logic                  cfg_wr;
   logic                  cfg_sel;
   logic [LINE_LEN_W-1:0] new_len;
   len_type               new_eff;
   logic                  len_chg;

   // pipeline
   logic   s1_vld_ff, s2_vld_ff, s3_vld_ff, s4_vld_ff, s5_vld_ff;
   s1_type s1_ff, s1_in;
   s2_type s2_ff, s2_in;
   s3_type s3_ff, s3_in;
   s4_type s4_ff, s4_in;
   s5_type s5_ff, s5_in;

   addr_type wp_ff, wp_in;
   len_type  fill_ff, fill_in;
   logic [Q_CNT_W-1:0] pend_ff, pend_in;

   logic              req_acc;
   logic              rsp_acc;
   logic [DIFF_W-1:0] diff;
   len_type           len_m1;
   addr_type          off;
   logic [SUM_W-1:0]  sum1;
   addr_type          idx1;
   logic [SUM_W-1:0]  wp_inc;
   addr_type          wp_next;
   logic              advance;
   logic [SUM_W-1:0]  inc2;
   addr_type          idx2;
   logic              fwd1;
   sample_type        data1;
   sample_type        sum3;
   sample_type        d2;
   sample_type        y;

   addr_type   ram_raddr;
   sample_type ram_rdata;
   logic       ram_we;
   q_ctl_type  q_ctl;

   // configuration port
   assign cfg_wr = csr_psel & csr_penable & csr_pwrite;
   assign cfg_sel = csr_paddr[CSR_IDX_BIT];
   assign new_len = csr_pwdata[LINE_LEN_W-1:0];
   assign new_eff = (CSR_DATA_W'(new_len) > CSR_DATA_W'(MAX_LINE_LENGTH)) ?
                    LEN_W'(MAX_LINE_LENGTH) : LEN_W'(new_len);
   assign len_chg = cfg_wr & (cfg_sel == REG_LINE_LENGTH) & (new_eff != eff_len_ff);
   assign csr_pready = 1'b1;

   always_comb begin
      line_len_in = line_len_ff;
      eff_len_in = eff_len_ff;
      pass_in = pass_ff;
      if (cfg_wr) begin
         case (cfg_sel)
            REG_LINE_LENGTH: begin
               line_len_in = new_len;
               eff_len_in = new_eff;
            end
            REG_PASSTHROUGH: begin
               pass_in = csr_pwdata[0];
            end
            default: begin
               pass_in = pass_ff;
            end
         endcase
      end
   end

   always_comb begin
      case (cfg_sel)
         REG_LINE_LENGTH: csr_prdata = CSR_DATA_W'(line_len_ff);
         REG_PASSTHROUGH: csr_prdata = CSR_DATA_W'(pass_ff);
         default:         csr_prdata = '0;
      endcase
   end

   // handshakes and output credit
   assign req_stall = s1_vld_ff | (pend_ff == Q_CNT_W'(Q_DEPTH));
   assign req_acc = req_valid & ~req_stall;
   assign rsp_acc = rsp_valid & ~rsp_stall;
   assign pend_in = pend_ff + Q_CNT_W'(req_acc) - Q_CNT_W'(rsp_acc);

   // accept: read offset from length and delay
   assign diff = DIFF_W'(eff_len_ff) - DIFF_W'(req_delay_samples);
   assign len_m1 = eff_len_ff - LEN_W'(1);

   always_comb begin
      if (diff[DIFF_W-1]) begin
         off = '0;
      end else if (diff >= DIFF_W'(eff_len_ff)) begin
         off = len_m1[ADDR_W-1:0];
      end else begin
         off = diff[ADDR_W-1:0];
      end
      s1_in.byp = pass_ff | (eff_len_ff == '0);
      s1_in.byp_val = pass_ff ? req_sample_in : '0;
      s1_in.x = req_sample_in;
      s1_in.ffg = req_feedforward_gain;
      s1_in.fbg = req_feedback_gain;
      s1_in.off = off;
   end

   // stage 1: feedback read address, advance write position
   assign sum1 = SUM_W'(wp_ff) + SUM_W'(s1_ff.off);
   assign idx1 = (sum1 >= SUM_W'(eff_len_ff)) ? ADDR_W'(sum1 - SUM_W'(eff_len_ff)) :
                 ADDR_W'(sum1);
   assign wp_inc = SUM_W'(wp_ff) + SUM_W'(1);
   assign wp_next = (wp_inc >= SUM_W'(eff_len_ff)) ? '0 : ADDR_W'(wp_inc);
   assign advance = s1_vld_ff & ~s1_ff.byp;

   always_comb begin
      wp_in = wp_ff;
      fill_in = fill_ff;
      if (len_chg) begin
         wp_in = '0;
         fill_in = '0;
      end else if (advance) begin
         wp_in = wp_next;
         if (fill_ff < eff_len_ff) begin
            fill_in = fill_ff + LEN_W'(1);
         end
      end
   end

   always_comb begin
      s2_in.byp = s1_ff.byp;
      s2_in.byp_val = s1_ff.byp_val;
      s2_in.x = s1_ff.x;
      s2_in.ffg = s1_ff.ffg;
      s2_in.fbg = s1_ff.fbg;
      s2_in.wp = wp_ff;
      s2_in.idx1 = idx1;
      s2_in.v1 = (LEN_W'(idx1) < fill_ff);
   end

   // stage 2: feedback product, feedforward read address
   assign inc2 = SUM_W'(s2_ff.idx1) + SUM_W'(1);
   assign idx2 = (inc2 >= SUM_W'(eff_len_ff)) ? '0 : ADDR_W'(inc2);
   // entry written by the item now in stage 4 lands with this read
   assign fwd1 = s4_vld_ff & ~s4_ff.byp & (s4_ff.wp == s2_ff.idx1);

   always_comb begin
      if (fwd1) begin
         data1 = s4_ff.sum;
      end else if (s2_ff.v1) begin
         data1 = ram_rdata;
      end else begin
         data1 = '0;
      end
      s3_in.byp = s2_ff.byp;
      s3_in.byp_val = s2_ff.byp_val;
      s3_in.x = s2_ff.x;
      s3_in.ffg = s2_ff.ffg;
      s3_in.wp = s2_ff.wp;
      s3_in.prod1 = data1 * s2_ff.fbg;
      s3_in.v2 = (LEN_W'(idx2) < fill_ff);
      s3_in.fwd2 = (idx2 == s2_ff.wp);
   end

   assign ram_raddr = s1_vld_ff ? idx1 : idx2;

   // stage 3: feedback sum, write back
   assign sum3 = round_sat(s3_ff.x, s3_ff.prod1);
   assign ram_we = s3_vld_ff & ~s3_ff.byp;

   always_comb begin
      if (s3_ff.fwd2) begin
         d2 = sum3;
      end else if (s3_ff.v2) begin
         d2 = ram_rdata;
      end else begin
         d2 = '0;
      end
      s4_in.byp = s3_ff.byp;
      s4_in.byp_val = s3_ff.byp_val;
      s4_in.wp = s3_ff.wp;
      s4_in.sum = sum3;
      s4_in.d2 = d2;
      s4_in.ffg = s3_ff.ffg;
   end

   // stage 4: feedforward product
   always_comb begin
      s5_in.byp = s4_ff.byp;
      s5_in.byp_val = s4_ff.byp_val;
      s5_in.sum = s4_ff.sum;
      s5_in.prod2 = s4_ff.d2 * s4_ff.ffg;
   end

   // stage 5: output sum
   assign y = s5_ff.byp ? s5_ff.byp_val : round_sat(s5_ff.sum, s5_ff.prod2);
   assign q_ctl.push = s5_vld_ff;
   assign q_ctl.pop = rsp_acc;

   always_ff @(posedge clock) begin
      if (reset) begin
         line_len_ff <= '0;
         eff_len_ff <= '0;
         pass_ff <= 1'b0;
         wp_ff <= '0;
         fill_ff <= '0;
         pend_ff <= '0;
         s1_vld_ff <= 1'b0;
         s2_vld_ff <= 1'b0;
         s3_vld_ff <= 1'b0;
         s4_vld_ff <= 1'b0;
         s5_vld_ff <= 1'b0;
      end else begin
         line_len_ff <= line_len_in;
         eff_len_ff <= eff_len_in;
         pass_ff <= pass_in;
         wp_ff <= wp_in;
         fill_ff <= fill_in;
         pend_ff <= pend_in;
         s1_vld_ff <= req_acc;
         s2_vld_ff <= s1_vld_ff;
         s3_vld_ff <= s2_vld_ff;
         s4_vld_ff <= s3_vld_ff;
         s5_vld_ff <= s4_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (req_acc) begin
         s1_ff <= s1_in;
      end
      s2_ff <= s2_in;
      s3_ff <= s3_in;
      s4_ff <= s4_in;
      s5_ff <= s5_in;
   end

   cff_ram #(
      .WIDTH (SAMPLE_W),
      .DEPTH (MAX_LINE_LENGTH)
   ) u_store (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (s3_ff.wp),
      .wr_data (sum3),
      .rd_addr (ram_raddr),
      .rd_data (ram_rdata)
   );

   cff_out_q u_out_q (
      .clock     (clock),
      .reset     (reset),
      .ctl       (q_ctl),
      .push_data (y),
      .q_valid   (rsp_valid),
      .q_data    (rsp_sample_out)
   );

   a_pend_bound: assert property (@(posedge clock) disable iff (reset)
      pend_ff <= Q_CNT_W'(Q_DEPTH))
      else $error("more items in flight than output queue entries");

   a_read_port: assert property (@(posedge clock) disable iff (reset)
      !(s1_vld_ff && s2_vld_ff))
      else $error("store read port claimed by two items");

   a_wp_range: assert property (@(posedge clock) disable iff (reset)
      (eff_len_ff != '0) |-> (LEN_W'(wp_ff) < eff_len_ff))
      else $error("write position beyond line length");

   a_fill_range: assert property (@(posedge clock) disable iff (reset)
      fill_ff <= eff_len_ff)
      else $error("fill count beyond line length");

   a_write_after_read: assert property (@(posedge clock) disable iff (reset)
      (s1_vld_ff && !s1_ff.byp) |=> ##1 ram_we)
      else $error("filtered item did not write back");

endmodule
